/* hdl/rba_pkg.sv */
// Shared types and codes for the ring buffer allocator.
// No dependencies; used by rba_cell, ring_buffer_allocator_core, rba_checker and tb_top.
package rba_pkg;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_UNKNOWN  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic REG_POOL_SIZE    = 1'b0;
  localparam logic REG_BASE_ADDRESS = 1'b1;

  // Row-wide control broadcast to every cell.
  typedef struct packed {
    logic shift;   // take the right neighbor's entry
    logic push;    // write the selected cell
    logic search;  // compare and mark on free
  } rba_cell_ctl_t;

endpackage

/* hdl/rba_cell.sv */
// One queue position of the allocation table: offset, length, freed flag.
// Depends on rba_pkg.
module rba_cell import rba_pkg::*; #(
  parameter int ADDR_BITS = 40
) (
  input  logic                 clk,
  input  rba_cell_ctl_t        ctl,
  input  logic                 live,
  input  logic                 sel,
  input  logic [ADDR_BITS-1:0] nb_off,
  input  logic [ADDR_BITS-1:0] nb_len,
  input  logic                 nb_freed,
  input  logic [ADDR_BITS-1:0] wr_off,
  input  logic [ADDR_BITS-1:0] wr_len,
  input  logic [ADDR_BITS-1:0] base,
  input  logic [ADDR_BITS-1:0] where,
  input  logic                 hit_in,
  output logic                 hit_out,
  output logic [ADDR_BITS-1:0] off_o,
  output logic [ADDR_BITS-1:0] len_o,
  output logic                 freed_o
);

  logic [ADDR_BITS-1:0] off_r;
  logic [ADDR_BITS-1:0] len_r;
  logic                 freed_r;
  logic [ADDR_BITS-1:0] blk_addr;
  logic                 match;

  assign blk_addr = base + off_r;
  assign match    = ctl.search && live && !freed_r && (blk_addr == where);
  assign hit_out  = hit_in | match;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      off_r   <= nb_off;
      len_r   <= nb_len;
      freed_r <= nb_freed;
    end else if (ctl.push && sel) begin
      off_r   <= wr_off;
      len_r   <= wr_len;
      freed_r <= 1'b0;
    end else if (match && !hit_in) begin
      // only the oldest match is marked
      freed_r <= 1'b1;
    end
  end

  assign off_o   = off_r;
  assign len_o   = len_r;
  assign freed_o = freed_r;

endmodule

/* hdl/ring_buffer_allocator_core.sv */
// Ring buffer allocator: a row of cells holds live blocks in FIFO order.
// An allocate passes S_ALLOC, S_PLACE and S_RESP (S_ALLOC then S_RESP when full), a clear
// goes straight to S_RESP, and a free passes S_FREE, S_POP for each block retired and S_RESP
// (S_FREE then S_RESP when unknown); a stalled result holds the input. No new item is taken
//   until the last result is loaded; the one-position-a-cycle shift of the cell row sets the cost of a free.
// Reset (rst_n low, synchronous): queue empty, pool_size 2^30, base 0; cells hold no reset.
module ring_buffer_allocator_core import rba_pkg::*; #(
  parameter int MAX_ALLOCS = 64,
  parameter int ADDR_BITS  = 40
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_op,
  input  logic [ADDR_BITS-1:0]            in_amount,
  input  logic [ADDR_BITS-1:0]            in_free_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [ADDR_BITS-1:0]            out_address,
  output logic [ADDR_BITS-1:0]            out_bytes_left,
  output logic [$clog2(MAX_ALLOCS+1)-1:0] out_live_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_addr,
  input  logic [ADDR_BITS-1:0]            cfg_data
);

  localparam int CW = $clog2(MAX_ALLOCS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ALLOCS);
  localparam logic [ADDR_BITS-1:0] POOL_RESET = ADDR_BITS'(64'd1073741824);

  typedef enum logic [2:0] {
    S_IDLE, S_ALLOC, S_PLACE, S_FREE, S_POP, S_RESP
  } state_t;

  state_t               state_r;
  logic [ADDR_BITS-1:0] pool_r, base_r;
  logic [CW-1:0]        cnt_r;
  logic [ADDR_BITS-1:0] qbytes_r, last_off_r, end_r;
  logic [ADDR_BITS-1:0] amt_r, where_r, tail_r, addr_r;
  logic [ADDR_BITS:0]   epl_r;
  logic                 wrap_ok_r, inner_ok_r, contig_r;
  logic [1:0]           status_r;
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [ADDR_BITS-1:0] out_address_r, out_bytes_left_r;
  logic [CW-1:0]        out_live_count_r;

  // Cell row wiring
  rba_cell_ctl_t        ctl;
  logic [ADDR_BITS-1:0] c_off [MAX_ALLOCS];
  logic [ADDR_BITS-1:0] c_len [MAX_ALLOCS];
  logic                 c_freed [MAX_ALLOCS];
  logic                 hit [MAX_ALLOCS+1];

  // Placement decision
  logic                 place_ok;
  logic [ADDR_BITS-1:0] place_off;
  logic [ADDR_BITS:0]   amt2;

  assign amt2 = {amt_r, 1'b0};

  always_comb begin
    place_ok  = 1'b0;
    place_off = '0;
    if (cnt_r == '0) begin
      place_ok = (amt_r <= pool_r);
    end else if (contig_r) begin
      if (epl_r <= {1'b0, pool_r}) begin
        place_ok  = 1'b1;
        // big request in the tail: align to the pool end
        place_off = (amt2 > {1'b0, tail_r}) ? (pool_r - amt_r) : end_r;
      end else if (wrap_ok_r) begin
        place_ok = 1'b1;
      end
    end else if (inner_ok_r) begin
      place_ok  = 1'b1;
      place_off = end_r;
    end
  end

  assign ctl.shift  = (state_r == S_POP) && (cnt_r != '0) && c_freed[0];
  assign ctl.push   = (state_r == S_PLACE) && place_ok;
  assign ctl.search = (state_r == S_FREE);

  assign hit[0] = 1'b0;

  for (genvar k = 0; k < MAX_ALLOCS; k++) begin : g_cell
    logic [ADDR_BITS-1:0] nb_off, nb_len;
    logic                 nb_freed;
    if (k + 1 < MAX_ALLOCS) begin : g_nb
      assign nb_off   = c_off[k+1];
      assign nb_len   = c_len[k+1];
      assign nb_freed = c_freed[k+1];
    end else begin : g_end
      assign nb_off   = '0;
      assign nb_len   = '0;
      assign nb_freed = 1'b0;
    end
    rba_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .live     (CW'(k) < cnt_r),
      .sel      (cnt_r == CW'(k)),
      .nb_off   (nb_off),
      .nb_len   (nb_len),
      .nb_freed (nb_freed),
      .wr_off   (place_off),
      .wr_len   (amt_r),
      .base     (base_r),
      .where    (where_r),
      .hit_in   (hit[k]),
      .hit_out  (hit[k+1]),
      .off_o    (c_off[k]),
      .len_o    (c_len[k]),
      .freed_o  (c_freed[k])
    );
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pool_r      <= POOL_RESET;
      base_r      <= '0;
      cnt_r       <= '0;
      qbytes_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_addr == REG_POOL_SIZE) pool_r <= cfg_data;
        else                           base_r <= cfg_data;
      end
      // drop the sent result unless a new one is loaded below
      if (out_valid_r && out_ready && (state_r != S_RESP)) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            amt_r    <= (in_amount == '0) ? ADDR_BITS'(1) : in_amount;
            where_r  <= in_free_address;
            status_r <= ST_OK;
            addr_r   <= '0;
            case (in_op)
              OP_ALLOC: state_r <= S_ALLOC;
              OP_FREE:  state_r <= S_FREE;
              OP_CLEAR: begin
                cnt_r    <= '0;
                qbytes_r <= '0;
                state_r  <= S_RESP;
              end
              default:  state_r <= S_RESP;
            endcase
          end
        end
        S_ALLOC: begin
          // register the sums so the placement check sees only compares
          epl_r      <= {1'b0, end_r} + {1'b0, amt_r};
          tail_r     <= pool_r - end_r;
          wrap_ok_r  <= (amt_r <= c_off[0]);
          inner_ok_r <= ({1'b0, end_r} + {1'b0, amt_r}) <= {1'b0, c_off[0]};
          contig_r   <= (c_off[0] <= last_off_r);
          if (cnt_r == CNT_MAX) begin
            status_r <= ST_FULL;
            state_r  <= S_RESP;
          end else begin
            state_r  <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (place_ok) begin
            cnt_r      <= cnt_r + CW'(1);
            qbytes_r   <= qbytes_r + amt_r;
            last_off_r <= place_off;
            end_r      <= place_off + amt_r;
            addr_r     <= base_r + place_off;
          end else begin
            status_r <= ST_NO_SPACE;
          end
          state_r <= S_RESP;
        end
        S_FREE: begin
          if (hit[MAX_ALLOCS]) begin
            state_r <= S_POP;
          end else begin
            status_r <= ST_UNKNOWN;
            state_r  <= S_RESP;
          end
        end
        S_POP: begin
          // retire one freed head per cycle; the row shifts left
          if (ctl.shift) begin
            cnt_r    <= cnt_r - CW'(1);
            qbytes_r <= qbytes_r - c_len[0];
          end else begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r      <= 1'b1;
            out_status_r     <= status_r;
            out_address_r    <= addr_r;
            out_bytes_left_r <= (pool_r > qbytes_r) ? (pool_r - qbytes_r) : '0;
            out_live_count_r <= cnt_r;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_address    = out_address_r;
  assign out_bytes_left = out_bytes_left_r;
  assign out_live_count = out_live_count_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX) else $error("queue count beyond table depth");

  a_empty_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (qbytes_r == '0)) else $error("bytes queued with empty queue");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("item accepted while busy");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> (cnt_r < CNT_MAX)) else $error("push into full table");

endmodule

/* sim/rba_checker.sv */
// Scoreboard for the ring buffer allocator: mirrors pool state, predicts each result.
// Depends on rba_pkg; instantiated by tb_top beside the core.
`timescale 1ns / 100ps
module rba_checker import rba_pkg::*; #(
  parameter int MAX_ALLOCS = 64,
  parameter int ADDR_BITS  = 40
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [1:0]                      in_op,
  input  logic [ADDR_BITS-1:0]            in_amount,
  input  logic [ADDR_BITS-1:0]            in_free_address,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [1:0]                      out_status,
  input  logic [ADDR_BITS-1:0]            out_address,
  input  logic [ADDR_BITS-1:0]            out_bytes_left,
  input  logic [$clog2(MAX_ALLOCS+1)-1:0] out_live_count,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic                            cfg_addr,
  input  logic [ADDR_BITS-1:0]            cfg_data,
  output int                              fail_count,
  output int                              pending
);

  typedef struct packed {
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] address;
    logic [ADDR_BITS-1:0] bytes_left;
    logic [6:0]           live;
  } alloc_result_t;

  alloc_result_t result_q[$];

  logic [ADDR_BITS-1:0] pool_bytes, pool_base, used_bytes;
  logic [ADDR_BITS-1:0] blk_off[MAX_ALLOCS];
  logic [ADDR_BITS-1:0] blk_len[MAX_ALLOCS];
  logic                 blk_freed[MAX_ALLOCS];
  int                   head, tail, nlive;

  assign pending = result_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic void push_block(input logic [ADDR_BITS-1:0] off,
                                     input logic [ADDR_BITS-1:0] len);
    blk_off[tail] = off;
    blk_len[tail] = len;
    blk_freed[tail] = 1'b0;
    tail = (tail + 1) % MAX_ALLOCS;
    nlive++;
    used_bytes += len;
  endfunction

  // Work out one allocation; use 41-bit sums so end + amount never wraps.
  function automatic logic [1:0] place_block(input logic [ADDR_BITS-1:0] amt_in,
                                             output logic [ADDR_BITS-1:0] addr);
    logic [ADDR_BITS:0]   amt, fin, front, last_off;
    logic [ADDR_BITS-1:0] off;
    logic                 ok;
    int                   last;
    amt = (amt_in == '0) ? (ADDR_BITS+1)'(1) : {1'b0, amt_in};
    addr = '0;
    ok = 1'b0;
    off = '0;
    if (nlive >= MAX_ALLOCS) return ST_FULL;
    if (nlive == 0) begin
      ok = amt <= {1'b0, pool_bytes};
    end else begin
      last = (head + nlive - 1) % MAX_ALLOCS;
      front = {1'b0, blk_off[head]};
      last_off = {1'b0, blk_off[last]};
      fin = last_off + {1'b0, blk_len[last]};
      if (front <= last_off) begin
        if (fin + amt <= {1'b0, pool_bytes}) begin
          off = ((amt << 1) > {1'b0, pool_bytes} - fin) ?
                ADDR_BITS'({1'b0, pool_bytes} - amt) : fin[ADDR_BITS-1:0];
          ok = 1'b1;
        end else if (amt <= front) begin
          ok = 1'b1;
        end
      end else if (fin + amt <= front) begin
        off = fin[ADDR_BITS-1:0];
        ok = 1'b1;
      end
    end
    if (!ok) return ST_NO_SPACE;
    push_block(off, amt[ADDR_BITS-1:0]);
    addr = pool_base + off;
    return ST_OK;
  endfunction

  function automatic logic [1:0] release_block(input logic [ADDR_BITS-1:0] where);
    int s;
    for (int k = 0; k < nlive; k++) begin
      s = (head + k) % MAX_ALLOCS;
      if (!blk_freed[s] && (pool_base + blk_off[s]) == where) begin
        blk_freed[s] = 1'b1;
        while (nlive > 0 && blk_freed[head]) begin
          used_bytes -= blk_len[head];
          head = (head + 1) % MAX_ALLOCS;
          nlive--;
        end
        return ST_OK;
      end
    end
    return ST_UNKNOWN;
  endfunction

  always @(posedge clk) begin
    alloc_result_t exp_r, got;
    if (!rst_n) begin
      pool_bytes <= 40'd1073741824;
      pool_base  <= '0;
      used_bytes = '0;
      head = 0;
      tail = 0;
      nlive = 0;
      fail_count = 0;
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_addr == REG_POOL_SIZE) pool_bytes <= cfg_data;
        else pool_base <= cfg_data;
      end
      if (in_valid && in_ready) begin
        exp_r = '0;
        case (in_op)
          OP_ALLOC: exp_r.status = place_block(in_amount, exp_r.address);
          OP_FREE:  exp_r.status = release_block(in_free_address);
          OP_CLEAR: begin
            head = 0;
            tail = 0;
            nlive = 0;
            used_bytes = '0;
          end
          default: ;
        endcase
        exp_r.bytes_left = (pool_bytes > used_bytes) ? pool_bytes - used_bytes : '0;
        exp_r.live = 7'(nlive);
        result_q.insert(result_q.size(), exp_r);
      end
      if (out_valid && out_ready) begin
        got = '{out_status, out_address, out_bytes_left, 7'(out_live_count)};
        if (result_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          exp_r = result_q[0];
          result_q.delete(0);
          if (got.status != exp_r.status) report("status", got.status, exp_r.status);
          if (got.address != exp_r.address) report("address", got.address, exp_r.address);
          if (got.bytes_left != exp_r.bytes_left)
            report("bytes_left", got.bytes_left, exp_r.bytes_left);
          if (got.live != exp_r.live) report("live_count", got.live, exp_r.live);
        end
      end
    end
  end

endmodule

/* sim/tb_top.sv */
// Top of the allocator testbench: clock, reset, stimulus, config phases, verdict.
// Depends on rba_pkg, rba_checker and ring_buffer_allocator_core.
`timescale 1ns / 100ps
module tb_top;
  import rba_pkg::*;

  localparam int AB = 40;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0, cfg_addr = 1'b0;
  logic [1:0] in_op = OP_ALLOC;
  logic [AB-1:0] in_amount = '0, in_free_address = '0, cfg_data = '0;
  logic in_ready, out_valid, cfg_ready;
  logic [1:0] out_status;
  logic [AB-1:0] out_address, out_bytes_left;
  logic [6:0] out_live_count;
  int fail_count, pending;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  // Remember recent allocated addresses so frees mostly hit live blocks.
  logic [AB-1:0] handed_out[$];
  logic [AB-1:0] pool_now = 40'd1073741824;

  always #1 clk = ~clk;

  ring_buffer_allocator_core u_dut (.*);

  rba_checker u_chk (.*);

  // Track addresses handed out on successful allocates.
  always @(posedge clk) begin
    if (out_valid && out_ready && out_status == ST_OK && out_address != '0)
      handed_out.insert(handed_out.size(), out_address);
    if (handed_out.size() > 80) handed_out.delete(0);
  end

  // Receiver: random stalls per item, or a long hold-off when asked.
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // Watchdog: count cycles with no handshake on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
        !rst_n || hold_off)
      idle_cycles <= 0;
    else if (!stim_done || pending > 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ring_buffer_allocator_core test failed");
      $finish;
    end
  end

  function automatic logic [AB-1:0] rand40();
    return AB'({$urandom, $urandom});
  endfunction

  // Valid stays high into the next item when there is no gap; callers that
  // pause the input drop it themselves.
  task automatic send_item(input logic [1:0] op, input logic [AB-1:0] amt,
                           input logic [AB-1:0] fa, input bit no_gap);
    int gap;
    gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_amount <= amt;
    in_free_address <= fa;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait out results, then the latency margin before touching registers.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending > 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [AB-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    if (idx == REG_POOL_SIZE) pool_now = val;
  endtask

  function automatic logic [AB-1:0] pick_amount();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return rand40();
      2: return pool_now >> $urandom_range(1, 4);
      default: return (pool_now >> $urandom_range(4, 8)) + $urandom_range(0, 3);
    endcase
  endfunction

  // One random item: mostly allocate/free of live addresses, a little noise.
  task automatic random_item(input bit no_gap);
    int r;
    logic [AB-1:0] fa;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      send_item(OP_ALLOC, pick_amount(), rand40(), no_gap);
    end else if (r < 92) begin
      if (handed_out.size() > 0 && $urandom_range(0, 9) != 0) begin
        r = $urandom_range(0, handed_out.size() - 1);
        fa = handed_out[r];
        handed_out.delete(r);
      end else begin
        fa = rand40();
      end
      send_item(OP_FREE, rand40(), fa, no_gap);
    end else if (r < 96) begin
      send_item(OP_CLEAR, rand40(), rand40(), no_gap);
    end else begin
      send_item(OP_NOP, rand40(), rand40(), no_gap);
    end
  endtask

  initial begin
    logic [AB-1:0] pools[4];
    logic [AB-1:0] bases[4];
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, every op, table full, unknown free, wrap of address.
    send_item(OP_ALLOC, '0, '0, 1'b0);
    send_item(OP_ALLOC, 40'hFF_FFFF_FFFF, '0, 1'b0);
    send_item(OP_FREE, '0, 40'hFF_FFFF_FFFF, 1'b0);
    send_item(OP_FREE, '0, '0, 1'b0);
    send_item(OP_NOP, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b0);
    send_item(OP_CLEAR, '0, '0, 1'b0);
    for (int i = 0; i < 66; i++) send_item(OP_ALLOC, 40'd16, '0, 1'b1);
    send_item(OP_CLEAR, '0, '0, 1'b0);
    drain();
    write_reg(REG_BASE_ADDRESS, 40'hFF_FFFF_FFF0);
    write_reg(REG_POOL_SIZE, 40'd100);
    send_item(OP_ALLOC, 40'd10, '0, 1'b0);
    send_item(OP_ALLOC, 40'd60, '0, 1'b0);
    send_item(OP_FREE, '0, 40'hFF_FFFF_FFF0, 1'b0);
    send_item(OP_ALLOC, 40'd20, '0, 1'b0);
    send_item(OP_ALLOC, 40'd200, '0, 1'b0);
    drain();
    write_reg(REG_POOL_SIZE, 40'd1);
    send_item(OP_ALLOC, 40'd5, '0, 1'b0);

    pools = '{40'hFF_FFFF_FFFF, 40'd1000, 40'd1, 40'd4096};
    bases = '{40'h0, 40'h12_3456_7000, 40'hFF_FFFF_FF00, 40'hFF_FFFF_FFFF};
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      handed_out.delete();
      write_reg(REG_POOL_SIZE, pools[ph]);
      write_reg(REG_BASE_ADDRESS, bases[ph]);
      for (int i = 0; i < 175; i++) begin
        if (ph == 1 && i == 50) begin
          hold_off = 1'b1;
          for (int k = 0; k < 20; k++) random_item(1'b1);
        end
        if (ph == 2 && i == 100) begin
          in_valid <= 1'b0;
          while (pending > 0) @(negedge clk);
        end
        // Shrink the pool below queued data once, mid-phase, while idle.
        if (ph == 3 && i == 100) begin
          drain();
          write_reg(REG_POOL_SIZE, 40'd64);
        end
        random_item(ph == 0 && i < 40);
      end
    end

    in_valid <= 1'b0;
    stim_done = 1'b1;
    while (pending > 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) $display("ring_buffer_allocator_core test passed");
    else $display("ring_buffer_allocator_core test failed");
    $finish;
  end

endmodule

/* ring_buffer_allocator_core.f */
hdl/rba_pkg.sv
hdl/rba_cell.sv
hdl/ring_buffer_allocator_core.sv
sim/rba_checker.sv
sim/tb_top.sv
